// ----- design/lkv_pkg.sv -----
// ---------------------------------------------------------------------------
// lkv_pkg
// shared codes, defaults and the token control type of the key/value chain
// ---------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  // default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // field widths of the stream ports
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // control part of an operation token moving down the chain
  typedef struct packed {
    logic              vld;
    logic [KIND_W-1:0] kind;
    logic              done;
  } token_ctrl_t;

endpackage

`default_nettype wire

// ----- design/lkv_cell.sv -----
// ---------------------------------------------------------------------------
// lkv_cell
// one table slot; checks the passing token and hands it to the next slot
// ---------------------------------------------------------------------------
`default_nettype none

module lkv_cell #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire lkv_pkg::token_ctrl_t in_ctrl,
  input  wire [KEY_BITS-1:0]      in_key,
  input  wire [VALUE_BITS-1:0]    in_value,
  input  wire [VALUE_BITS-1:0]    in_rdata,
  output lkv_pkg::token_ctrl_t    out_ctrl,
  output logic [KEY_BITS-1:0]     out_key,
  output logic [VALUE_BITS-1:0]   out_value,
  output logic [VALUE_BITS-1:0]   out_rdata
);

  logic                         slot_valid;
  logic [KEY_BITS-1:0]          slot_key;
  logic [VALUE_BITS-1:0]        slot_value;
  logic                         key_eq;
  logic                         hit;
  logic                         out_vld;
  logic [lkv_pkg::KIND_W-1:0]   out_kind;
  logic                         out_done;

  assign key_eq   = (slot_key == in_key);
  assign out_ctrl = '{vld: out_vld, kind: out_kind, done: out_done};

  // first-hit rule: only a token not yet served may act here
  always_comb begin
    hit = 1'b0;
    if (in_ctrl.vld && !in_ctrl.done) begin
      case (in_ctrl.kind)
        lkv_pkg::KIND_PUT: hit = !slot_valid || key_eq;
        lkv_pkg::KIND_GET: hit = slot_valid && key_eq;
        lkv_pkg::KIND_DEL: hit = slot_valid && key_eq;
        default:           hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      out_vld    <= 1'b0;
    end else if (en) begin
      out_vld <= in_ctrl.vld;
      if (hit && in_ctrl.kind == lkv_pkg::KIND_PUT) begin
        slot_valid <= 1'b1;
      end else if (hit && in_ctrl.kind == lkv_pkg::KIND_DEL) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind  <= in_ctrl.kind;
      out_done  <= in_ctrl.done || hit;
      out_key   <= in_key;
      out_value <= in_value;
      out_rdata <= (hit && in_ctrl.kind == lkv_pkg::KIND_GET) ? slot_value : in_rdata;
      if (hit && in_ctrl.kind == lkv_pkg::KIND_PUT) begin
        slot_key   <= in_key;
        slot_value <= in_value;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/linear_key_value_table.sv -----
// from input transfer to result: ENTRIES slot cells, then one output register
// throughput: one operation per cycle while the result is not stalled; each slot sees operations in arrival order, so a
//   following operation always finds that slot as left by the ones before it
// a stalled result freezes the whole chain until it is taken
// reset (rst, synchronous, active high): all slots free, chain and output empty
// ---------------------------------------------------------------------------
// linear_key_value_table
// key/value table searched in slot order with first-hit priority; each
// operation travels down a row of slot cells, and the first cell that fits
// serves it (put: free or same key, get/delete: valid and same key)
// ---------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table #(
  parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // operation stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // key [31:0], value [63:32]
  input  wire  [1:0]  s_tuser,   // kind [1:0]
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata    // status [1:0], read_value [33:2], zero [39:34]
);

  // token taps between cells; tap 0 is the incoming transfer
  lkv_pkg::token_ctrl_t  ctrl  [0:ENTRIES];
  logic [KEY_BITS-1:0]   key   [0:ENTRIES];
  logic [VALUE_BITS-1:0] value [0:ENTRIES];
  logic [VALUE_BITS-1:0] rdata [0:ENTRIES];

  logic                          en;
  logic [lkv_pkg::STATUS_W-1:0]  status_next;

  // whole chain moves when the output slot is free or being emptied
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign ctrl[0].vld  = s_tvalid;
  assign ctrl[0].kind = s_tuser;
  assign ctrl[0].done = 1'b0;
  assign key[0]       = KEY_BITS'(s_tdata[31:0]);
  assign value[0]     = VALUE_BITS'(s_tdata[63:32]);
  assign rdata[0]     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_ctrl   (ctrl[i]),
      .in_key    (key[i]),
      .in_value  (value[i]),
      .in_rdata  (rdata[i]),
      .out_ctrl  (ctrl[i+1]),
      .out_key   (key[i+1]),
      .out_value (value[i+1]),
      .out_rdata (rdata[i+1])
    );
  end

  // a token that left the last cell unserved failed its search
  always_comb begin
    status_next = lkv_pkg::ST_OK;
    if (!ctrl[ENTRIES].done) begin
      case (ctrl[ENTRIES].kind)
        lkv_pkg::KIND_PUT: status_next = lkv_pkg::ST_FULL;
        lkv_pkg::KIND_GET: status_next = lkv_pkg::ST_MISSING;
        lkv_pkg::KIND_DEL: status_next = lkv_pkg::ST_MISSING;
        default:           status_next = lkv_pkg::ST_OK;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctrl[ENTRIES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'd0, 32'(rdata[ENTRIES]), status_next};
    end
  end

  // only a found get carries a value
  a_value_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != lkv_pkg::ST_OK |-> m_tdata[33:2] == 32'd0)
    else $error("nonzero read_value on a failed operation");

  // no status code beyond table full
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("illegal status code");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:34] == 6'd0)
    else $error("result padding not zero");

  // nothing leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
